>>> rtl/sust_pkg.sv
// shared types and constants for the sorted unique set table
package sust_pkg;

  localparam int unsigned CapacityDef = 16;
  localparam int unsigned KeyW        = 32;
  localparam int unsigned PosW        = 5;
  localparam int unsigned CntW        = 5;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_LOOKUP = 2'd2,
    MODE_OTHER  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_DELETED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FOUND     = 3'd4,
    ST_FULL      = 3'd5
  } status_e;

  typedef struct packed {
    logic [1:0]             mode;
    logic signed [KeyW-1:0] key;
  } in_t;

  typedef struct packed {
    logic [2:0]      status;
    logic [PosW-1:0] position;
    logic [CntW-1:0] count;
  } out_t;

  // shift commands broadcast to every cell
  typedef struct packed {
    logic ins;
    logic del;
  } cell_ctrl_t;

endpackage

>>> rtl/sust_cell.sv
// one storage cell of the key chain: compare, boundary detect and shift
module sust_cell
  import sust_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   descending_i,
  input  logic signed [KeyW-1:0] key_i,
  input  logic                   occ_i,
  input  logic                   prefix_i,
  input  logic signed [KeyW-1:0] prev_key_i,
  input  logic signed [KeyW-1:0] next_key_i,
  input  cell_ctrl_t             ctrl_i,
  output logic signed [KeyW-1:0] key_o,
  output logic                   prefix_o,
  output logic                   bound_o,
  output logic                   hit_o
);

  logic signed [KeyW-1:0] key_q, key_d;
  logic                   ahead;

  assign ahead    = descending_i ? (key_i < key_q) : (key_q < key_i);
  // stays high while every cell so far is occupied and orders before the key
  assign prefix_o = prefix_i & occ_i & ahead;
  assign bound_o  = prefix_i & ~prefix_o;
  assign hit_o    = bound_o & occ_i & (key_q == key_i);
  assign key_o    = key_q;

  always_comb begin
    key_d = key_q;
    if (ctrl_i.ins && !prefix_o) begin
      key_d = bound_o ? key_i : prev_key_i;
    end else if (ctrl_i.del && !prefix_o) begin
      key_d = next_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

endmodule

>>> rtl/sorted_unique_set_table.sv
// Sorted unique set table: bounded set of distinct signed keys kept in order.
// Input channel in_valid_i/in_stall_o carries a transaction with a mode
// (insert, delete, lookup) and a signed key. Output channel
// out_valid_o/out_stall_i returns one transaction per input: status,
// position of the key in the order (or where it would go) and the count.
// cfg_we_i/cfg_data_i writes the order bit (1 descending); write only idle.
// A transaction is captured in the request register; from there the whole
// cell chain compares against the key, shifts in place and loads the output
// register. A new transaction is taken only once the last one has left the
// single request register in front of the cell chain.
// While the output is stalled the request waits in its register and the
// input stalls; the cell chain changes only when the result is loaded.
// Reset empties the table (count zero) and selects ascending order; cell
// contents are not cleared, entries beyond the count are never reported.
module sorted_unique_set_table
  import sust_pkg::*;
#(
  parameter int unsigned CAPACITY = CapacityDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_data_i,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic          desc_q;
  logic          req_v_q;
  in_t           req_q;
  logic          out_v_q;
  out_t          out_q, out_d;
  logic [CW-1:0] count_q, count_d;

  logic signed [KeyW-1:0] cell_key [CAPACITY];
  logic [CAPACITY:0]      prefix;
  logic [CAPACITY-1:0]    bound;
  logic [CAPACITY-1:0]    hit;
  cell_ctrl_t             ctrl;

  logic          commit, present, full;
  logic [CW-1:0] enc, pos;
  logic [31:0]   pos_ext, cnt_ext;
  status_e       status;

  assign in_stall_o  = req_v_q;
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  assign commit = req_v_q & (~out_v_q | ~out_stall_i);

  assign prefix[0] = 1'b1;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [KeyW-1:0] prev_key, next_key;
    if (i == 0) begin : g_first
      assign prev_key = req_q.key;
    end else begin : g_mid
      assign prev_key = cell_key[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign next_key = cell_key[i];
    end else begin : g_inner
      assign next_key = cell_key[i+1];
    end

    sust_cell u_cell (
      .clk_i        (clk_i),
      .descending_i (desc_q),
      .key_i        (req_q.key),
      .occ_i        (CW'(i) < count_q),
      .prefix_i     (prefix[i]),
      .prev_key_i   (prev_key),
      .next_key_i   (next_key),
      .ctrl_i       (ctrl),
      .key_o        (cell_key[i]),
      .prefix_o     (prefix[i+1]),
      .bound_o      (bound[i]),
      .hit_o        (hit[i])
    );
  end

  // boundary is at most one-hot, so the index encode is a plain or
  always_comb begin
    enc = '0;
    for (int unsigned i = 0; i < CAPACITY; i++) begin
      enc = enc | (bound[i] ? CW'(i) : '0);
    end
  end

  assign pos     = (|bound) ? enc : CW'(CAPACITY);
  assign present = |hit;
  assign full    = (count_q == CW'(CAPACITY));

  always_comb begin
    ctrl    = '0;
    count_d = count_q;
    unique case (mode_e'(req_q.mode))
      MODE_INSERT: begin
        if (present) begin
          status = ST_DUPLICATE;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          status   = ST_INSERTED;
          ctrl.ins = commit;
          if (commit) count_d = count_q + CW'(1);
        end
      end
      MODE_DELETE: begin
        if (present) begin
          status   = ST_DELETED;
          ctrl.del = commit;
          if (commit) count_d = count_q - CW'(1);
        end else begin
          status = ST_NOT_FOUND;
        end
      end
      default: begin
        status = present ? ST_FOUND : ST_NOT_FOUND;
      end
    endcase
  end

  always_comb begin
    pos_ext         = 32'(pos);
    cnt_ext         = 32'(count_d);
    out_d.status    = status;
    out_d.position  = pos_ext[PosW-1:0];
    out_d.count     = cnt_ext[CntW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      desc_q  <= 1'b0;
      req_v_q <= 1'b0;
      out_v_q <= 1'b0;
      count_q <= '0;
    end else begin
      if (cfg_we_i) desc_q <= cfg_data_i;
      if (in_valid_i && !in_stall_o) begin
        req_v_q <= 1'b1;
      end else if (commit) begin
        req_v_q <= 1'b0;
      end
      if (commit) begin
        out_v_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_v_q <= 1'b0;
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) req_q <= in_data_i;
    if (commit) out_q <= out_d;
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("stored count above capacity");

  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.ins |=> count_q == $past(count_q) + CW'(1))
    else $error("insert did not grow the count");

  a_commit_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> out_v_q && !req_v_q)
    else $error("committed request did not reach the output");

  a_bound_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_v_q |-> $onehot0(bound))
    else $error("more than one chain boundary");
`endif

endmodule
